FILE: design/pksk_pkg.sv
// pksk_pkg: shared types and codes for the pressed key set table
// used by pksk_cell and pressed_key_set_table_unit, no dependencies
`default_nettype none

package pksk_pkg;

    // operation selector, the unused code behaves as a peek
    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_PEEK   = 2'd2,
        FUNC_SPARE  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        STAT_DONE      = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_PRESENT   = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_EMPTY     = 3'd4
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // control broadcast to every cell of the row
    typedef struct packed {
        logic cmp;  // latch key compare
        logic ins;  // write key into the cell at the fill point
        logic rem;  // compact the row from the matching cell upward
    } t_cell_ctl;

    localparam int unsigned KEY_W   = 8;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned CNT_W   = 3;
    localparam int unsigned SHOWN   = 6;
    localparam logic [IDX_W-1:0] IDX_NONE = '1;

endpackage

`default_nettype wire

FILE: design/pressed_key_set_table_unit.sv
// pressed_key_set_table_unit: top level of the pressed key set table
// instantiates a row of pksk_cell, uses pksk_pkg
//
// ordered table of held key codes, oldest first, up to KEY_SLOTS entries
// input channel: i_in_valid / o_in_ready carry i_func and i_key; insert
//   appends an absent key if room is left, remove deletes a key and
//   compacts later slots down, peek only reports
// output channel: o_out_valid / i_out_ready carry one result per transfer:
//   count, the first six slots (zero when unused), top key, the slot the
//   key was found in before the operation (-1 if absent or peek) and status
// timing: the transfer edge latches the key compare in every cell and moves to
//   the run state; at the end of the run state the cells commit their new keys
//   and the result register loads
// the input side stays closed in the run state, so a new input is not taken
//   before the cell row has committed the last one
// a waiting result does not block the next input transfer when the
//   receiver takes it in the same cycle; a stalled receiver holds the
//   result and the input side waits
// reset (synchronous, active low) empties the table and clears all slots
// to zero
`default_nettype none

module pressed_key_set_table_unit #(
    parameter int unsigned KEY_SLOTS = 6
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [pksk_pkg::KEY_W-1:0]    i_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [pksk_pkg::CNT_W-1:0]         o_count,
    output logic [pksk_pkg::KEY_W-1:0]         o_slot_0,
    output logic [pksk_pkg::KEY_W-1:0]         o_slot_1,
    output logic [pksk_pkg::KEY_W-1:0]         o_slot_2,
    output logic [pksk_pkg::KEY_W-1:0]         o_slot_3,
    output logic [pksk_pkg::KEY_W-1:0]         o_slot_4,
    output logic [pksk_pkg::KEY_W-1:0]         o_slot_5,
    output logic [pksk_pkg::KEY_W-1:0]         o_top_key,
    output logic signed [pksk_pkg::IDX_W-1:0]  o_found_index,
    output logic [pksk_pkg::CNT_W-1:0]         o_status
);

    localparam int unsigned CW = $clog2(KEY_SLOTS + 1);
    localparam int unsigned IW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam logic [CW-1:0] FULL_CNT = CW'(KEY_SLOTS);

    // control state
    pksk_pkg::t_state r_state;
    pksk_pkg::t_state n_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    logic             n_out_valid;

    // latched operation
    pksk_pkg::t_func            r_func;
    logic [pksk_pkg::KEY_W-1:0] r_key;

    // result register
    logic [pksk_pkg::CNT_W-1:0] r_res_count;
    logic [pksk_pkg::KEY_W-1:0] r_slot [pksk_pkg::SHOWN];
    logic [pksk_pkg::KEY_W-1:0] r_top;
    logic [pksk_pkg::IDX_W-1:0] r_where;
    pksk_pkg::t_status          r_status;

    // cell row wiring
    pksk_pkg::t_cell_ctl        w_ctl;
    logic [pksk_pkg::KEY_W-1:0] w_cell_key_in;
    logic [pksk_pkg::KEY_W-1:0] w_key [KEY_SLOTS];
    logic [pksk_pkg::KEY_W-1:0] w_nxt [KEY_SLOTS];
    logic [KEY_SLOTS:0]         w_shift;
    logic [KEY_SLOTS-1:0]       w_match;
    logic [pksk_pkg::KEY_W-1:0] w_show [pksk_pkg::SHOWN];

    logic                       w_in_xfer;
    logic                       w_found;
    logic [pksk_pkg::IDX_W-1:0] w_idx;
    logic [pksk_pkg::IDX_W-1:0] w_where;
    pksk_pkg::t_status          w_status;
    logic [pksk_pkg::KEY_W-1:0] w_top;
    logic [IW-1:0]              w_top_sel;
    logic [7:0]                 w_count_ext;

    // input side opens in the idle state once the result slot is free or drains this cycle
    assign o_in_ready = (r_state == pksk_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_xfer  = i_in_valid && o_in_ready;

    // cells compare against the port key at transfer, write the latched key
    assign w_cell_key_in = (r_state == pksk_pkg::ST_IDLE) ? i_key : r_key;
    assign w_shift[0]    = 1'b0;

    for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_cell
        logic [pksk_pkg::KEY_W-1:0] w_up;
        if (g == KEY_SLOTS - 1) begin : g_last
            assign w_up = '0;
        end else begin : g_mid
            assign w_up = w_key[g + 1];
        end
        pksk_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_key      (w_cell_key_in),
            .i_used     (CW'(g) < r_count),
            .i_here     (CW'(g) == r_count),
            .i_shift_in (w_shift[g]),
            .i_next_key (w_up),
            .o_shift_out(w_shift[g + 1]),
            .o_key      (w_key[g]),
            .o_key_next (w_nxt[g]),
            .o_match    (w_match[g])
        );
    end

    // shown slots come straight from the next cell keys, zero past the row
    for (genvar s = 0; s < pksk_pkg::SHOWN; s++) begin : g_show
        if (s < KEY_SLOTS) begin : g_real
            assign w_show[s] = w_nxt[s];
        end else begin : g_pad
            assign w_show[s] = '0;
        end
    end

    // match vector is one-hot at most, keys in the table are distinct
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (w_match[i]) begin
                w_idx = w_idx | pksk_pkg::IDX_W'(i);
            end
        end
    end
    assign w_found = |w_match;

    // commit decision and result fields
    always_comb begin
        w_ctl       = '0;
        w_ctl.cmp   = w_in_xfer;
        n_count     = r_count;
        w_where     = pksk_pkg::IDX_NONE;
        w_status    = pksk_pkg::STAT_DONE;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            pksk_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    n_state = pksk_pkg::ST_RUN;
                end
            end
            pksk_pkg::ST_RUN: begin
                n_state     = pksk_pkg::ST_IDLE;
                n_out_valid = 1'b1;
                unique case (r_func)
                    pksk_pkg::FUNC_INSERT: begin
                        if (w_found) begin
                            w_where  = w_idx;
                            w_status = pksk_pkg::STAT_PRESENT;
                        end else if (r_count == FULL_CNT) begin
                            w_status = pksk_pkg::STAT_FULL;
                        end else begin
                            w_ctl.ins = 1'b1;
                            n_count   = r_count + CW'(1);
                        end
                    end
                    pksk_pkg::FUNC_REMOVE: begin
                        if (w_found) begin
                            w_where   = w_idx;
                            w_ctl.rem = 1'b1;
                            n_count   = r_count - CW'(1);
                        end else begin
                            w_status = pksk_pkg::STAT_NOT_FOUND;
                        end
                    end
                    pksk_pkg::FUNC_PEEK, pksk_pkg::FUNC_SPARE: begin
                        if (r_count == '0) begin
                            w_status = pksk_pkg::STAT_EMPTY;
                        end
                    end
                    default: begin
                        w_status = pksk_pkg::STAT_DONE;
                    end
                endcase
            end
            default: begin
                n_state = pksk_pkg::ST_IDLE;
            end
        endcase
    end

    // top key is the newest entry after the commit
    assign w_top_sel   = IW'(n_count - CW'(1));
    assign w_top       = (n_count == '0) ? '0 : w_nxt[w_top_sel];
    assign w_count_ext = 8'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pksk_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // latched operation, loaded on the input transfer
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_func <= pksk_pkg::t_func'(i_func);
            r_key  <= i_key;
        end
    end

    // result register, loaded in the commit cycle
    always_ff @(posedge i_clk) begin
        if (r_state == pksk_pkg::ST_RUN) begin
            r_res_count <= w_count_ext[pksk_pkg::CNT_W-1:0];
            r_top       <= w_top;
            r_where     <= w_where;
            r_status    <= w_status;
            for (int s = 0; s < pksk_pkg::SHOWN; s++) begin
                r_slot[s] <= w_show[s];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_count       = r_res_count;
    assign o_slot_0      = r_slot[0];
    assign o_slot_1      = r_slot[1];
    assign o_slot_2      = r_slot[2];
    assign o_slot_3      = r_slot[3];
    assign o_slot_4      = r_slot[4];
    assign o_slot_5      = r_slot[5];
    assign o_top_key     = r_top;
    assign o_found_index = r_where;
    assign o_status      = r_status;

    // unused cells hold zero: reset clears the row and a remove shifts
    // zero in from the top of the row
`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("held count above table size");

    a_match_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pksk_pkg::ST_RUN) |-> $onehot0(w_match))
        else $error("key matched in more than one slot");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> ##1 o_out_valid)
        else $error("result missing after input transfer");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !o_in_ready)
        else $error("second transfer taken during commit cycle");
`endif

endmodule

`default_nettype wire

FILE: design/pksk_cell.sv
// pksk_cell: one slot of the key table, holds a key code and its match flag
// depends on pksk_pkg
`default_nettype none

module pksk_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire pksk_pkg::t_cell_ctl         i_ctl,
    input  wire logic [pksk_pkg::KEY_W-1:0]  i_key,
    input  wire logic                        i_used,
    input  wire logic                        i_here,
    input  wire logic                        i_shift_in,
    input  wire logic [pksk_pkg::KEY_W-1:0]  i_next_key,
    output logic                             o_shift_out,
    output logic [pksk_pkg::KEY_W-1:0]       o_key,
    output logic [pksk_pkg::KEY_W-1:0]       o_key_next,
    output logic                             o_match
);

    logic [pksk_pkg::KEY_W-1:0] r_key;
    logic [pksk_pkg::KEY_W-1:0] n_key;
    logic                       r_match;
    logic                       n_match;

    // compaction starts at the matching cell and ripples up the row
    assign o_shift_out = i_shift_in | r_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp) begin
            n_match = i_used && (i_key == r_key);
        end
        n_key = r_key;
        if (i_ctl.rem && (i_shift_in || r_match)) begin
            n_key = i_next_key;
        end else if (i_ctl.ins && i_here) begin
            n_key = i_key;
        end
    end

    // key resets to zero: unused slots always read zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_key   <= '0;
        end else begin
            r_match <= n_match;
            r_key   <= n_key;
        end
    end

    assign o_key      = r_key;
    assign o_key_next = n_key;
    assign o_match    = r_match;

endmodule

`default_nettype wire

FILE: test/tb_pressed_key_set_table_unit.sv
// tb_pressed_key_set_table_unit: self-checking bench for the pressed key set table
// drives insert/remove/peek transfers with bursty gaps and a stalling receiver,
// predicts every result in-bench; depends on pksk_pkg and pressed_key_set_table_unit
`default_nettype none

module tb_pressed_key_set_table_unit;

    localparam int TABLE_DEPTH = 6;
    localparam int DIRECT_EVENTS = 24;
    localparam int RANDOM_EVENTS = 1350;
    localparam int POOL_KEYS = 9;

    // one key event as offered on the input channel
    typedef struct packed {
        pksk_pkg::t_func op;
        logic [7:0]      key;
    } t_key_event;

    // table snapshot carried by one result transfer
    typedef struct packed {
        logic [pksk_pkg::CNT_W-1:0]                  count;
        logic [pksk_pkg::SHOWN-1:0][pksk_pkg::KEY_W-1:0] slots;
        logic [pksk_pkg::KEY_W-1:0]                  top;
        logic signed [pksk_pkg::IDX_W-1:0]           found;
        pksk_pkg::t_status                           status;
    } t_table_view;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic        in_valid = 1'b0;
    t_key_event  cur_event = '{op: pksk_pkg::FUNC_PEEK, key: 8'h00};
    logic        out_ready = 1'b0;

    logic                                o_in_ready;
    logic                                o_out_valid;
    logic [pksk_pkg::CNT_W-1:0]          o_count;
    logic [pksk_pkg::KEY_W-1:0]          o_slot_0, o_slot_1, o_slot_2;
    logic [pksk_pkg::KEY_W-1:0]          o_slot_3, o_slot_4, o_slot_5;
    logic [pksk_pkg::KEY_W-1:0]          o_top_key;
    logic signed [pksk_pkg::IDX_W-1:0]   o_found_index;
    logic [pksk_pkg::CNT_W-1:0]          o_status;

    pressed_key_set_table_unit #(
        .KEY_SLOTS(TABLE_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (cur_event.op),
        .i_key        (cur_event.key),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (out_ready),
        .o_count      (o_count),
        .o_slot_0     (o_slot_0),
        .o_slot_1     (o_slot_1),
        .o_slot_2     (o_slot_2),
        .o_slot_3     (o_slot_3),
        .o_slot_4     (o_slot_4),
        .o_slot_5     (o_slot_5),
        .o_top_key    (o_top_key),
        .o_found_index(o_found_index),
        .o_status     (o_status)
    );

    // 12 unit period
    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // key events still to offer, and table snapshots still to receive
    t_key_event  key_events[$];
    t_table_view expected_views[$];
    int          mismatches = 0;

    // shadow copy of the table, oldest key first
    logic [7:0] held_keys[TABLE_DEPTH];
    int         held_cnt = 0;

    initial begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            held_keys[i] = 8'h00;
        end
    end

    function automatic int find_held(input logic [7:0] k);
        for (int i = 0; i < held_cnt; i++) begin
            if (held_keys[i] == k) begin
                return i;
            end
        end
        return -1;
    endfunction

    // update the shadow table for one accepted event and queue the snapshot
    task automatic apply_key_event(input pksk_pkg::t_func op, input logic [7:0] k);
        int                where;
        pksk_pkg::t_status st;
        t_table_view       v;
        where = -1;
        st = pksk_pkg::STAT_DONE;
        case (op)
            pksk_pkg::FUNC_INSERT: begin
                // presence wins over a full table
                where = find_held(k);
                if (where >= 0) begin
                    st = pksk_pkg::STAT_PRESENT;
                end else if (held_cnt >= TABLE_DEPTH) begin
                    st = pksk_pkg::STAT_FULL;
                end else begin
                    held_keys[held_cnt] = k;
                    held_cnt++;
                end
            end
            pksk_pkg::FUNC_REMOVE: begin
                where = find_held(k);
                if (where < 0) begin
                    st = pksk_pkg::STAT_NOT_FOUND;
                end else begin
                    // close the gap, order kept, freed slot cleared
                    for (int i = where; i < held_cnt - 1; i++) begin
                        held_keys[i] = held_keys[i + 1];
                    end
                    held_keys[held_cnt - 1] = 8'h00;
                    held_cnt--;
                end
            end
            default: begin
                // peek and the spare code never look at the key
                if (held_cnt == 0) begin
                    st = pksk_pkg::STAT_EMPTY;
                end
            end
        endcase
        v.count = held_cnt[pksk_pkg::CNT_W-1:0];
        for (int i = 0; i < pksk_pkg::SHOWN; i++) begin
            v.slots[i] = (i < held_cnt) ? held_keys[i] : 8'h00;
        end
        v.top = (held_cnt > 0) ? held_keys[held_cnt - 1] : 8'h00;
        v.found = where[pksk_pkg::IDX_W-1:0];
        v.status = st;
        expected_views.push_back(v);
    endtask

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, what, want, got);
        end
    endtask

    // compare the result now on the output ports with one snapshot
    task automatic check_against_dut(input t_table_view want);
        logic [pksk_pkg::SHOWN-1:0][pksk_pkg::KEY_W-1:0] got_slots;
        got_slots = {o_slot_5, o_slot_4, o_slot_3, o_slot_2, o_slot_1, o_slot_0};
        check_field("count", want.count, o_count);
        for (int i = 0; i < pksk_pkg::SHOWN; i++) begin
            check_field($sformatf("slot_%0d", i), want.slots[i], got_slots[i]);
        end
        check_field("top_key", want.top, o_top_key);
        check_field("found_index", int'($signed(want.found)), int'($signed(o_found_index)));
        check_field("status", int'(want.status), o_status);
    endtask

    // driver: bursts of transfers separated by random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                apply_key_event(cur_event.op, cur_event.key);
            end
            // offer a new event only when nothing is pending on the channel
            if (!in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (key_events.size() > 0) begin
                    cur_event <= key_events.pop_front();
                    in_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // end of burst, pick the next gap and burst length
                        case ($urandom_range(0, 9))
                            0, 1, 2: gap_left = 0;
                            9:       gap_left = $urandom_range(6, 20);
                            default: gap_left = $urandom_range(1, 5);
                        endcase
                        burst_left = $urandom_range(0, 15);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each result transfer, receiver stalls on a rotating pattern
    logic [15:0] ready_pat = 16'hFFFF;
    int          pat_pos = 0;
    int          pat_life = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (expected_views.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none got count %0d status %0d",
                             $time, o_count, o_status);
                end else begin
                    check_against_dut(expected_views.pop_front());
                end
            end
            if (pat_life == 0) begin
                // some stretches always ready, otherwise a fresh pattern
                if ($urandom_range(0, 9) < 3) begin
                    ready_pat = 16'hFFFF;
                end else begin
                    ready_pat = 16'($urandom) | 16'h0001;
                end
                pat_life = $urandom_range(20, 200);
            end
            pat_life--;
            out_ready <= ready_pat[pat_pos];
            pat_pos = (pat_pos + 1) % 16;
        end
    end

    task automatic push_event(input pksk_pkg::t_func op, input logic [7:0] k);
        key_events.push_back('{op: op, key: k});
    endtask

    initial begin
        logic [7:0]      pool[POOL_KEYS];
        int              r;
        pksk_pkg::t_func op;
        logic [7:0]      k;

        // directed: empty table, zero and all-ones keys, full table, compaction
        push_event(pksk_pkg::FUNC_PEEK,   8'hFF);
        push_event(pksk_pkg::FUNC_REMOVE, 8'h00);
        push_event(pksk_pkg::FUNC_INSERT, 8'h00);
        push_event(pksk_pkg::FUNC_INSERT, 8'hFF);
        push_event(pksk_pkg::FUNC_INSERT, 8'h00);
        push_event(pksk_pkg::FUNC_SPARE,  8'h12);
        push_event(pksk_pkg::FUNC_INSERT, 8'h5A);
        push_event(pksk_pkg::FUNC_INSERT, 8'hA5);
        push_event(pksk_pkg::FUNC_INSERT, 8'h3C);
        push_event(pksk_pkg::FUNC_INSERT, 8'hC3);
        push_event(pksk_pkg::FUNC_INSERT, 8'h81);
        push_event(pksk_pkg::FUNC_INSERT, 8'h3C);
        push_event(pksk_pkg::FUNC_PEEK,   8'h00);
        push_event(pksk_pkg::FUNC_REMOVE, 8'hA5);
        push_event(pksk_pkg::FUNC_REMOVE, 8'h81);
        push_event(pksk_pkg::FUNC_INSERT, 8'h81);
        push_event(pksk_pkg::FUNC_REMOVE, 8'h81);
        push_event(pksk_pkg::FUNC_REMOVE, 8'h00);
        push_event(pksk_pkg::FUNC_REMOVE, 8'hFF);
        push_event(pksk_pkg::FUNC_REMOVE, 8'h5A);
        push_event(pksk_pkg::FUNC_REMOVE, 8'h3C);
        push_event(pksk_pkg::FUNC_REMOVE, 8'hC3);
        push_event(pksk_pkg::FUNC_PEEK,   8'h7E);
        push_event(pksk_pkg::FUNC_SPARE,  8'h00);

        // random: a small key pool keeps hits, full tables and removals frequent
        for (int n = 0; n < RANDOM_EVENTS; n++) begin
            if (n % 150 == 0) begin
                for (int j = 0; j < POOL_KEYS; j++) begin
                    pool[j] = 8'($urandom_range(0, 255));
                end
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
                op = pksk_pkg::FUNC_INSERT;
            end else if (r < 80) begin
                op = pksk_pkg::FUNC_REMOVE;
            end else if (r < 92) begin
                op = pksk_pkg::FUNC_PEEK;
            end else begin
                op = pksk_pkg::FUNC_SPARE;
            end
            if ($urandom_range(0, 9) < 8) begin
                k = pool[$urandom_range(0, POOL_KEYS - 1)];
            end else begin
                k = 8'($urandom_range(0, 255));
            end
            push_event(op, k);
        end

        // assert reset once, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every event accepted, every result received, then settle
        while (key_events.size() != 0 || in_valid) begin
            @(posedge i_clk);
        end
        while (expected_views.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5000000;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
